// ----- rtl/core/xtea_pkg.sv -----
// xtea_pkg: shared constants, types and the mix function of the xtea block cipher unit
// depends on nothing; used by the interfaces, controller, datapath, top level and checker

package xtea_pkg;

   localparam int unsigned CYCLES_DEFAULT = 32;

   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned KEY_WORDS       = 4;

   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9E3779B9;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_0_IDX = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_1_IDX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_2_IDX = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD_3_IDX = 3'd3;

   // operation codes of the kind field
   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic phase;
      logic publish;
   } cmd_type;

   // (v << 4 ^ v >> 5) + v
   function automatic logic [WORD_WIDTH-1:0] mix(input logic [WORD_WIDTH-1:0] v);
      mix = ((v << 4) ^ (v >> 5)) + v;
   endfunction

endpackage

// ----- rtl/core/xtea_if.sv -----
// xtea_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on xtea_pkg for the word and index widths

interface xtea_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [xtea_pkg::WORD_WIDTH-1:0]     block_left;
   logic [xtea_pkg::WORD_WIDTH-1:0]     block_right;

   modport source (output valid, kind, block_left, block_right, input ready);
   modport sink   (input valid, kind, block_left, block_right, output ready);
endinterface

interface xtea_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [xtea_pkg::WORD_WIDTH-1:0]     result_left;
   logic [xtea_pkg::WORD_WIDTH-1:0]     result_right;

   modport source (output valid, result_left, result_right, input ready);
   modport sink   (input valid, result_left, result_right, output ready);
endinterface

interface xtea_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [xtea_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [xtea_pkg::WORD_WIDTH-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/xtea_block_cipher_unit.sv -----
// xtea_block_cipher_unit: top level of the xtea cipher, controller plus datapath
// depends on xtea_pkg, xtea_if, xtea_ctrl and xtea_dp
//
//   channel   direction  carries                               handshake
//   req_if    in         kind, block_left, block_right         valid / ready
//   rsp_if    out        result_left, result_right             valid / ready
//   csr_if    in         index (key word 0..3), data           valid / ready, always ready
//
// a request runs all its half-rounds in ST_RUN, then ST_FINISH loads the output register
// and raises response valid together once the output slot is free; the unit then goes back
// to ST_IDLE and takes no new request before it is through with the last one
// the shared half-round unit does one add-xor-add per clock while running, two half-rounds per xtea cycle
// a finished response sits in an output register, so a stalled rsp side blocks only
// the next request's completion, not its acceptance
// reset clears the sequencer, response valid and all four key words to zero

module xtea_block_cipher_unit #(
   parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   xtea_req_if.sink         req_if,
   xtea_rsp_if.source       rsp_if,
   xtea_csr_if.sink         csr_if
);

   xtea_pkg::cmd_type cmd;
   logic              csr_write;

   // key registers take a write every cycle
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   // sequencer: idle, run the half-rounds, wait for the output slot
   xtea_ctrl #(
      .CYCLES    (CYCLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // datapath: keys, block halves, running sum, response register
   xtea_dp #(
      .CYCLES    (CYCLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_write (csr_write),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .req_kind  (req_if.kind),
      .req_left  (req_if.block_left),
      .req_right (req_if.block_right),
      .rsp_left  (rsp_if.result_left),
      .rsp_right (rsp_if.result_right)
   );

endmodule

// ----- rtl/core/xtea_ctrl.sv -----
// xtea_ctrl: sequencer of the xtea unit, half-round counter and response valid
// depends on xtea_pkg for state_type and cmd_type

module xtea_ctrl #(
   parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output xtea_pkg::cmd_type    cmd
);

   localparam int unsigned STEPS = 2 * CYCLES;
   localparam int unsigned CNT_W = (STEPS > 2) ? $clog2(STEPS) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   xtea_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xtea_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.phase    = count_ff[0];
      case (state_ff)
         xtea_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = xtea_pkg::ST_RUN;
            end
         end
         xtea_pkg::ST_RUN: begin
            cmd.step = 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = xtea_pkg::ST_FINISH;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         xtea_pkg::ST_FINISH: begin
            // wait for the output slot to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = xtea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = xtea_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/xtea_dp.sv -----
// xtea_dp: key registers, block and sum registers, one shared half-round unit, output register
// depends on xtea_pkg for widths, register indexes, cmd_type and mix

module xtea_dp #(
   parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  xtea_pkg::cmd_type                     cmd,
   input  logic                                  csr_write,
   input  logic [xtea_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]       csr_data,
   input  logic                                  req_kind,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]       req_left,
   input  logic [xtea_pkg::WORD_WIDTH-1:0]       req_right,
   output logic [xtea_pkg::WORD_WIDTH-1:0]       rsp_left,
   output logic [xtea_pkg::WORD_WIDTH-1:0]       rsp_right
);

   localparam int unsigned W = xtea_pkg::WORD_WIDTH;
   localparam logic [63:0] DEC_PRODUCT = 64'(xtea_pkg::DELTA) * 64'(CYCLES);
   localparam logic [W-1:0] DEC_START = DEC_PRODUCT[W-1:0];

   logic [W-1:0] key_ff [xtea_pkg::KEY_WORDS];
   logic [W-1:0] left_ff, right_ff, sum_ff;
   logic         dec_ff;
   logic [W-1:0] out_left_ff, out_right_ff;

   logic         use_low_bits;
   logic [1:0]   key_sel;
   logic         left_is_src;
   logic [W-1:0] src_word, dst_word, round_f, dst_in, sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < xtea_pkg::KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            xtea_pkg::KEY_WORD_0_IDX: key_ff[0] <= csr_data;
            xtea_pkg::KEY_WORD_1_IDX: key_ff[1] <= csr_data;
            xtea_pkg::KEY_WORD_2_IDX: key_ff[2] <= csr_data;
            xtea_pkg::KEY_WORD_3_IDX: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // encrypt: even step updates left with key by sum[1:0], odd updates right with sum[12:11]
   // decrypt: even step updates right with sum[12:11], odd updates left with sum[1:0]
   always_comb begin
      use_low_bits = dec_ff ? cmd.phase : !cmd.phase;
      key_sel      = use_low_bits ? sum_ff[1:0] : sum_ff[12:11];
      left_is_src  = dec_ff ^ cmd.phase;
      src_word     = left_is_src ? left_ff : right_ff;
      dst_word     = left_is_src ? right_ff : left_ff;
      round_f      = xtea_pkg::mix(src_word) ^ (sum_ff + key_ff[key_sel]);
      dst_in       = dec_ff ? (dst_word - round_f) : (dst_word + round_f);
      sum_in       = dec_ff ? (sum_ff - xtea_pkg::DELTA) : (sum_ff + xtea_pkg::DELTA);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff  <= req_left;
         right_ff <= req_right;
         dec_ff   <= req_kind;
         sum_ff   <= (req_kind == xtea_pkg::KIND_DECRYPT) ? DEC_START : '0;
      end else if (cmd.step) begin
         if (left_is_src) begin
            right_ff <= dst_in;
         end else begin
            left_ff <= dst_in;
         end
         if (!cmd.phase) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_left_ff  <= left_ff;
         out_right_ff <= right_ff;
      end
   end

   assign rsp_left  = out_left_ff;
   assign rsp_right = out_right_ff;

endmodule

// ----- rtl/core/xtea_chk.sv -----
// xtea_chk: port-level checks of the xtea unit, bound to the top level
// depends on xtea_pkg for widths and on xtea_block_cipher_unit as bind target

module xtea_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [xtea_pkg::WORD_WIDTH-1:0]   result_left,
   input logic [xtea_pkg::WORD_WIDTH-1:0]   result_right,
   input logic                              csr_valid,
   input logic                              csr_ready
);

   // a held response keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_left) && $stable(result_right))
      else $error("response changed while stalled");

   // the unit goes busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a new response only shows after a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response without work");

   // key writes are never stalled
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind xtea_block_cipher_unit xtea_chk u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .result_left  (rsp_if.result_left),
   .result_right (rsp_if.result_right),
   .csr_valid    (csr_if.valid),
   .csr_ready    (csr_if.ready)
);
